[src/gtfb_pkg.sv]
// Shared types and constants for the glyph text frame buffer.
// Used by every module of the block except gtfb_ram; depends on nothing else.
package gtfb_pkg;

  localparam int PAGE_COLUMNS  = 128;
  localparam int GLYPH_COLUMNS = 12;
  localparam int GLYPH_COUNT   = 95;
  localparam int PAGE_COUNT    = 4;

  localparam int FIRST_CODE  = 32;
  localparam int GLYPH_BYTES = 1 + 2 * GLYPH_COLUMNS;
  localparam int FONT_SIZE   = GLYPH_COUNT * GLYPH_BYTES;
  localparam int FONT_AW     = $clog2(FONT_SIZE);
  localparam int FONT_BANK_DEPTH = (FONT_SIZE + 1) / 2;
  localparam int FONT_BANK_AW    = $clog2(FONT_BANK_DEPTH);
  localparam int GLYPH_W     = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  // Frame rows: one row holds an even page column and the odd page column below it.
  localparam int ROW_COUNT = ((PAGE_COUNT + 1) / 2) * PAGE_COLUMNS;
  localparam int ROW_AW    = $clog2(ROW_COUNT);
  localparam int COL_W     = $clog2(PAGE_COLUMNS + GLYPH_COLUMNS);
  localparam int CNT_W     = $clog2(GLYPH_COLUMNS);
  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int FLUSH_HEAD = 3;
  localparam int OFF_W     = $clog2(PAGE_COLUMNS + FLUSH_HEAD);

  // Power of two: pointers wrap naturally.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] MODE_LOAD    = 3'd0;
  localparam logic [2:0] MODE_RESTART = 3'd1;
  localparam logic [2:0] MODE_DRAW    = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_FLUSH   = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_BADCHAR = 2'd2;

  localparam logic [7:0] CMD_COL_LOW  = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic [7:0] CMD_PAGE     = 8'hB0;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_DATA = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_ACK     = 3'd0,
    OP_LOAD    = 3'd1,
    OP_RESTART = 3'd2,
    OP_DRAW    = 3'd3,
    OP_BADCHAR = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_FLUSH   = 3'd6
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               line;
    logic [GLYPH_W-1:0] glyph;
    logic [FONT_AW-1:0] font_address;
    logic [7:0]         font_byte;
  } entry_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } result_t;

endpackage

[src/gtfb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the font banks and the frame banks.
module gtfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/gtfb_front.sv]
// Front end: accepts input items and classifies them into queue entries.
// Depends on gtfb_pkg.
module gtfb_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       mode,
  input  logic             line_select,
  input  logic [7:0]       char_code,
  input  logic [11:0]      font_address,
  input  logic [7:0]       font_byte,
  input  logic             q_full,
  output logic             push,
  output gtfb_pkg::entry_t entry
);

  logic char_ok;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign char_ok = (int'(char_code) >= gtfb_pkg::FIRST_CODE) &&
                   (int'(char_code) < gtfb_pkg::FIRST_CODE + gtfb_pkg::GLYPH_COUNT);

  always_comb begin
    entry.line         = line_select;
    entry.font_address = gtfb_pkg::FONT_AW'(font_address);
    entry.font_byte    = font_byte;
    // Keep the glyph index in range so the speculative width read stays in the font.
    entry.glyph        = '0;
    case (mode)
      gtfb_pkg::MODE_LOAD: begin
        entry.op = (int'(font_address) < gtfb_pkg::FONT_SIZE) ?
                   gtfb_pkg::OP_LOAD : gtfb_pkg::OP_ACK;
      end
      gtfb_pkg::MODE_RESTART: entry.op = gtfb_pkg::OP_RESTART;
      gtfb_pkg::MODE_DRAW: begin
        if (char_ok) begin
          entry.op    = gtfb_pkg::OP_DRAW;
          entry.glyph = gtfb_pkg::GLYPH_W'(char_code - 8'(gtfb_pkg::FIRST_CODE));
        end else begin
          entry.op = gtfb_pkg::OP_BADCHAR;
        end
      end
      gtfb_pkg::MODE_CLEAR: entry.op = gtfb_pkg::OP_CLEAR;
      gtfb_pkg::MODE_FLUSH: entry.op = gtfb_pkg::OP_FLUSH;
      default:              entry.op = gtfb_pkg::OP_ACK;
    endcase
  end

endmodule

[src/gtfb_queue.sv]
// Short queue of classified entries between the front and back ends.
// Depends on gtfb_pkg.
module gtfb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gtfb_pkg::entry_t push_entry,
  input  logic             pop,
  output gtfb_pkg::entry_t head,
  output logic             not_empty,
  output logic             full
);

  gtfb_pkg::entry_t slots [gtfb_pkg::QUEUE_DEPTH];
  logic [gtfb_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [gtfb_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [gtfb_pkg::QUEUE_AW:0]   count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (gtfb_pkg::QUEUE_AW+1)'(gtfb_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/gtfb_back.sv]
// Back end: executes queued entries against the font and frame stores.
// Depends on gtfb_pkg and gtfb_ram.
module gtfb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  gtfb_pkg::entry_t  head,
  output logic              pop,
  output logic              res_valid,
  input  logic              out_stall,
  output gtfb_pkg::result_t result
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WIDTH = 4'b0010,
    ST_COLS  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state;

  logic [7:0] cursor_top;
  logic [7:0] cursor_bottom;
  logic [gtfb_pkg::PAGE_W-1:0] flush_page;
  logic [gtfb_pkg::OFF_W-1:0]  flush_off;
  logic [gtfb_pkg::ROW_COUNT-1:0] row_valid;

  logic                         draw_line;
  logic [7:0]                   draw_cur;
  logic                         base_odd;
  logic [gtfb_pkg::FONT_AW-1:0] pair_addr;
  logic [gtfb_pkg::CNT_W-1:0]   col_cnt;
  logic                         flush_bank;
  logic                         flush_valid;
  logic                         flush_last;

  logic                              slot_free;
  logic [gtfb_pkg::FONT_AW-1:0]      base;
  logic [gtfb_pkg::FONT_AW-1:0]      font_raddr;
  logic [gtfb_pkg::FONT_BANK_AW-1:0] fb0_raddr;
  logic [gtfb_pkg::FONT_BANK_AW-1:0] fb1_raddr;
  logic [gtfb_pkg::FONT_BANK_AW-1:0] font_waddr;
  logic [7:0]                        fb0_rdata;
  logic [7:0]                        fb1_rdata;
  logic                              load_go;
  logic                              fb0_we;
  logic                              fb1_we;
  logic [7:0]                        glyph_width;
  logic [8:0]                        fit_sum;
  logic                              fits;
  logic [7:0]                        cursor_adv;
  logic [7:0]                        top_byte;
  logic [7:0]                        bottom_byte;
  logic [gtfb_pkg::COL_W-1:0]        col;
  logic                              top_ok;
  logic                              frame_we;
  logic [gtfb_pkg::ROW_AW-1:0]       row_wr;
  logic [gtfb_pkg::ROW_AW-1:0]       row_rd;
  logic [7:0]                        fr0_rdata;
  logic [7:0]                        fr1_rdata;
  logic                              page_last;
  logic                              off_last;
  logic [7:0]                        cmd_byte;
  gtfb_pkg::kind_t                   pop_kind;
  logic [7:0]                        pop_data;
  logic [1:0]                        pop_status;
  logic                              res_done;

  assign slot_free = !res_valid || !out_stall;
  assign pop       = (state == ST_IDLE) && q_valid && slot_free;

  // Font store: even addresses in bank 0, odd in bank 1, so a column pair
  // (top, bottom) comes out of the two banks together.
  assign base       = gtfb_pkg::FONT_AW'(int'(head.glyph) * gtfb_pkg::GLYPH_BYTES);
  assign font_raddr = (state == ST_IDLE) ? base : pair_addr;
  assign fb0_raddr  = gtfb_pkg::FONT_BANK_AW'((font_raddr >> 1) + font_raddr[0]);
  assign fb1_raddr  = gtfb_pkg::FONT_BANK_AW'(font_raddr >> 1);
  assign font_waddr = gtfb_pkg::FONT_BANK_AW'(head.font_address >> 1);
  assign load_go    = pop && (head.op == gtfb_pkg::OP_LOAD);
  assign fb0_we     = load_go && !head.font_address[0];
  assign fb1_we     = load_go && head.font_address[0];

  gtfb_ram #(.WIDTH(8), .DEPTH(gtfb_pkg::FONT_BANK_DEPTH)) u_font_even (
    .clk   (clk),
    .we    (fb0_we),
    .waddr (font_waddr),
    .wdata (head.font_byte),
    .raddr (fb0_raddr),
    .rdata (fb0_rdata)
  );

  gtfb_ram #(.WIDTH(8), .DEPTH(gtfb_pkg::FONT_BANK_DEPTH)) u_font_odd (
    .clk   (clk),
    .we    (fb1_we),
    .waddr (font_waddr),
    .wdata (head.font_byte),
    .raddr (fb1_raddr),
    .rdata (fb1_rdata)
  );

  assign glyph_width = base_odd ? fb1_rdata : fb0_rdata;
  assign fit_sum     = {1'b0, draw_cur} + {1'b0, glyph_width};
  assign fits        = fit_sum < 9'(gtfb_pkg::PAGE_COLUMNS);
  assign cursor_adv  = fit_sum[8] ? 8'hFF : fit_sum[7:0];
  // Pair addresses have the opposite parity of the glyph base.
  assign top_byte    = base_odd ? fb0_rdata : fb1_rdata;
  assign bottom_byte = base_odd ? fb1_rdata : fb0_rdata;

  // Frame store: even pages in one bank, odd pages in the other, same row.
  assign col      = gtfb_pkg::COL_W'(draw_cur) + gtfb_pkg::COL_W'(col_cnt);
  assign top_ok   = !draw_line || (gtfb_pkg::PAGE_COUNT > 2);
  assign frame_we = (state == ST_COLS) && top_ok && (int'(col) < gtfb_pkg::PAGE_COLUMNS);
  assign row_wr   = gtfb_pkg::ROW_AW'(int'(draw_line) * gtfb_pkg::PAGE_COLUMNS + int'(col));
  assign row_rd   = gtfb_pkg::ROW_AW'(int'(flush_page >> 1) * gtfb_pkg::PAGE_COLUMNS +
                                      int'(flush_off) - gtfb_pkg::FLUSH_HEAD);

  gtfb_ram #(.WIDTH(8), .DEPTH(gtfb_pkg::ROW_COUNT)) u_frame_even (
    .clk   (clk),
    .we    (frame_we),
    .waddr (row_wr),
    .wdata (top_byte),
    .raddr (row_rd),
    .rdata (fr0_rdata)
  );

  gtfb_ram #(.WIDTH(8), .DEPTH(gtfb_pkg::ROW_COUNT)) u_frame_odd (
    .clk   (clk),
    .we    (frame_we),
    .waddr (row_wr),
    .wdata (bottom_byte),
    .raddr (row_rd),
    .rdata (fr1_rdata)
  );

  assign page_last = (flush_page == gtfb_pkg::PAGE_W'(gtfb_pkg::PAGE_COUNT - 1));
  assign off_last  = (flush_off ==
                      gtfb_pkg::OFF_W'(gtfb_pkg::PAGE_COLUMNS + gtfb_pkg::FLUSH_HEAD - 1));

  always_comb begin
    if (flush_off == gtfb_pkg::OFF_W'(0)) begin
      cmd_byte = gtfb_pkg::CMD_COL_LOW;
    end else if (flush_off == gtfb_pkg::OFF_W'(1)) begin
      cmd_byte = gtfb_pkg::CMD_COL_HIGH;
    end else begin
      cmd_byte = gtfb_pkg::CMD_PAGE | 8'(flush_page);
    end
  end

  // Result fields known as soon as an entry is taken.
  always_comb begin
    pop_kind   = gtfb_pkg::KIND_ACK;
    pop_data   = 8'h00;
    pop_status = gtfb_pkg::STAT_OK;
    case (head.op)
      gtfb_pkg::OP_BADCHAR: pop_status = gtfb_pkg::STAT_BADCHAR;
      gtfb_pkg::OP_FLUSH: begin
        if (int'(flush_off) < gtfb_pkg::FLUSH_HEAD) begin
          pop_kind = gtfb_pkg::KIND_CMD;
          pop_data = cmd_byte;
        end
      end
      default: begin
      end
    endcase
  end

  // The result register is complete at the end of this cycle.
  always_comb begin
    case (state)
      ST_IDLE:  res_done = pop && (head.op != gtfb_pkg::OP_DRAW) &&
                           !((head.op == gtfb_pkg::OP_FLUSH) &&
                             (int'(flush_off) >= gtfb_pkg::FLUSH_HEAD));
      ST_WIDTH: res_done = !fits;
      ST_COLS:  res_done = (col_cnt == gtfb_pkg::CNT_W'(gtfb_pkg::GLYPH_COLUMNS - 1));
      ST_FLUSH: res_done = 1'b1;
      default:  res_done = 1'b0;
    endcase
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      result.kind   <= pop_kind;
      result.data   <= pop_data;
      result.last   <= 1'b0;
      result.status <= pop_status;
      draw_line     <= head.line;
      draw_cur      <= head.line ? cursor_bottom : cursor_top;
      base_odd      <= base[0];
      pair_addr     <= base + gtfb_pkg::FONT_AW'(1);
      col_cnt       <= '0;
      flush_bank    <= flush_page[0];
      flush_valid   <= row_valid[row_rd];
      flush_last    <= page_last && off_last;
    end
    case (state)
      ST_WIDTH: begin
        pair_addr <= pair_addr + gtfb_pkg::FONT_AW'(2);
        if (!fits) begin
          result.status <= gtfb_pkg::STAT_NOFIT;
        end
      end
      ST_COLS: begin
        col_cnt <= col_cnt + 1'b1;
        // Hold the address on the last pair so reads stay inside the font.
        if (int'(col_cnt) < gtfb_pkg::GLYPH_COLUMNS - 2) begin
          pair_addr <= pair_addr + gtfb_pkg::FONT_AW'(2);
        end
      end
      ST_FLUSH: begin
        result.kind <= gtfb_pkg::KIND_DATA;
        result.data <= flush_valid ? (flush_bank ? fr1_rdata : fr0_rdata) : 8'h00;
        result.last <= flush_last;
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cursor_top    <= '0;
      cursor_bottom <= '0;
      flush_page    <= '0;
      flush_off     <= '0;
      row_valid     <= '0;
      res_valid     <= 1'b0;
    end else begin
      res_valid <= res_done || (res_valid && out_stall);
      if (frame_we) begin
        row_valid[row_wr] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (head.op)
              gtfb_pkg::OP_DRAW: state <= ST_WIDTH;
              gtfb_pkg::OP_RESTART: begin
                if (head.line) begin
                  cursor_bottom <= '0;
                end else begin
                  cursor_top <= '0;
                end
              end
              gtfb_pkg::OP_CLEAR: begin
                row_valid <= '0;
              end
              gtfb_pkg::OP_FLUSH: begin
                if (int'(flush_off) >= gtfb_pkg::FLUSH_HEAD) begin
                  state <= ST_FLUSH;
                end
                if (off_last) begin
                  flush_off  <= '0;
                  flush_page <= page_last ? '0 : flush_page + 1'b1;
                end else begin
                  flush_off <= flush_off + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_WIDTH: begin
          if (draw_line) begin
            cursor_bottom <= cursor_adv;
          end else begin
            cursor_top <= cursor_adv;
          end
          if (fits) begin
            state <= ST_COLS;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_COLS: begin
          if (col_cnt == gtfb_pkg::CNT_W'(gtfb_pkg::GLYPH_COLUMNS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/glyph_text_frame_buffer_core.sv]
// Glyph text frame buffer: front classifier, 4-entry queue, execution back end.
// Load, restart, clear, unused modes, invalid characters and flush commands end in the idle
// state; flush data goes through ST_FLUSH, a glyph that does not fit through ST_WIDTH; a
// drawn glyph takes a width read, then one column pair a cycle from the two font banks.
// A drawn glyph, flush data or a misfit holds the back end; others leave it idle for the next.
// Reset (rst, synchronous) clears the queue, state, cursors, flush position and the frame row flags at once.
module glyph_text_frame_buffer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic        line_select,
  input  logic [7:0]  char_code,
  input  logic [11:0] font_address,
  input  logic [7:0]  font_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic        frame_last,
  output logic [1:0]  status
);

  gtfb_pkg::entry_t  push_entry;
  gtfb_pkg::entry_t  head;
  gtfb_pkg::result_t result;
  logic push;
  logic pop;
  logic q_valid;
  logic q_full;

  gtfb_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .line_select  (line_select),
    .char_code    (char_code),
    .font_address (font_address),
    .font_byte    (font_byte),
    .q_full       (q_full),
    .push         (push),
    .entry        (push_entry)
  );

  gtfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_valid),
    .full       (q_full)
  );

  gtfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .res_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign kind       = result.kind;
  assign out_byte   = result.data;
  assign frame_last = result.last;
  assign status     = result.status;

endmodule

[src/gtfb_checker.sv]
// Port-level checks on the result stream of the glyph text frame buffer.
// Depends on gtfb_pkg; bound to glyph_text_frame_buffer_core below.
module gtfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [7:0]  out_byte,
  input logic        frame_last,
  input logic [1:0]  status
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte) &&
                               $stable(frame_last) && $stable(status))
    else $error("stalled result changed");

  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> kind == gtfb_pkg::KIND_DATA)
    else $error("frame_last on a non-data byte");

  a_status_on_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != gtfb_pkg::STAT_OK |-> kind == gtfb_pkg::KIND_ACK)
    else $error("draw status on a stream byte");

  a_ack_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == gtfb_pkg::KIND_ACK |-> out_byte == 8'h00 && !frame_last)
    else $error("acknowledgement carries data");

  a_cmd_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == gtfb_pkg::KIND_CMD |->
      out_byte == gtfb_pkg::CMD_COL_LOW || out_byte == gtfb_pkg::CMD_COL_HIGH ||
      out_byte[7:4] == gtfb_pkg::CMD_PAGE[7:4])
    else $error("bad address command byte");

endmodule

bind glyph_text_frame_buffer_core gtfb_checker u_checker (.*);
